// File: rtl/bnms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnms_pkg: shared types and constants for box non-maximum suppression
// Field widths, stream packing, register codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package bnms_pkg;

    // Default sizing of the kept list and the per-frame box counter
    localparam int DEF_MAX_KEPT      = 128;
    localparam int DEF_MAX_PROPOSALS = 4096;

    // Field widths
    localparam int COORD_W  = 16;
    localparam int CLASS_W  = 8;
    localparam int AREA_W   = 32;
    localparam int THR_W    = 9;
    localparam int INDEX_W  = 12;
    localparam int TOTAL_W  = 8;

    // Stream packing
    localparam int IN_TDATA_W  = 4 * COORD_W + CLASS_W;   // 72 bits, whole bytes
    localparam int OUT_TDATA_W = 24;                      // 20 bits of fields + pad
    localparam int OUT_TUSER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = THR_W;

    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THRESHOLD  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_AGNOSTIC = CFG_IDX_W'(1);

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SPAN,
        S_AREA,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture the incoming box
        logic span;     // register width and height of the box
        logic area;     // register the box area
        logic issue;    // read one kept entry into the IoU pipeline
        logic commit;   // store the box if kept and room remains, emit the result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;   // kept list is empty
        logic scan_last;    // the entry being issued is the last kept one
        logic pipe_busy;    // comparisons still in flight
        logic out_free;     // the output register can take a result
    } t_status;

endpackage : bnms_pkg
`default_nettype wire

// File: rtl/box_non_max_suppression_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_non_max_suppression_top: greedy IoU non-maximum suppression
// Takes boxes sorted by descending score and reports keep/suppress per box.
// ----------------------------------------------------------------------------
// One box is handled at a time. Each box is compared with every box in the
// kept list (at most MAX_KEPT boxes) when it arrives, and the scan is skipped
// when the list is empty: the kept list sits in a memory with one write port
// and one registered read port that feeds one stored box per cycle into a
// shared five-stage IoU compare pipeline, followed by a drain of that
// pipeline and a commit. The next box can transfer once the result is
// registered and the block is idle again, later while the output stalls.
// A box is suppressed when intersection * 256 > iou_threshold * union with a
// kept box of its class (any class in class-agnostic mode). A box
// flagged first-of-frame on tuser empties the kept list and restarts the
// proposal index. A kept box that finds the list full is reported with keep
// set and list_overflow set but is not stored. Write configuration only
// while no box is in progress. The result register lets the next box start
// while a finished result waits on the output.
// ----------------------------------------------------------------------------
module box_non_max_suppression_top #(
    parameter int MAX_KEPT      = bnms_pkg::DEF_MAX_KEPT,
    parameter int MAX_PROPOSALS = bnms_pkg::DEF_MAX_PROPOSALS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // box stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [15:0] left_edge, [31:16] top_edge, [47:32] right_edge,
    // [63:48] bottom_edge, [71:64] class_label
    input  wire logic [bnms_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] first_of_frame
    input  wire logic                             i_s_axis_tuser,
    // result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [11:0] proposal_index, [19:12] kept_total, [23:20] zero
    output logic [bnms_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // [0] keep, [1] list_overflow
    output logic [bnms_pkg::OUT_TUSER_W-1:0]      o_m_axis_tuser,
    // configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [bnms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bnms_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bnms_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Registers accept a write every cycle
    assign o_cfg_ready = 1'b1;

    // Sequencer
    bnms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Storage and compare datapath
    bnms_datapath #(
        .MAX_KEPT      (MAX_KEPT),
        .MAX_PROPOSALS (MAX_PROPOSALS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_data  (i_s_axis_tdata),
        .i_box_first (i_s_axis_tuser),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule : box_non_max_suppression_top
`default_nettype wire

// File: rtl/bnms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnms_ctrl: sequencer for one box at a time
// Walks each box through size, area, a scan over the kept list unless empty,
// a drain of the IoU pipeline and the final commit to the output register.
// ----------------------------------------------------------------------------
module bnms_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire bnms_pkg::t_status i_status,
    output bnms_pkg::t_cmd         o_cmd
);
    import bnms_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                n_state = S_AREA;
            end
            S_AREA: begin
                n_state = i_status.count_zero ? S_DRAIN : S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
            end
            S_AREA: begin
                o_cmd.area = 1'b1;
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
            end
            S_DRAIN: begin
                o_cmd = '0;
            end
            S_FINISH: begin
                o_cmd.commit = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule : bnms_ctrl
`default_nettype wire

// File: rtl/bnms_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bnms_datapath: box registers, kept-list memory and shared IoU pipeline
// One kept entry enters the five-stage compare pipeline per cycle; any hit
// sets a sticky suppress flag. Also holds counters, config and output.
// ----------------------------------------------------------------------------
module bnms_datapath #(
    parameter int MAX_KEPT      = bnms_pkg::DEF_MAX_KEPT,
    parameter int MAX_PROPOSALS = bnms_pkg::DEF_MAX_PROPOSALS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // box input
    input  wire logic [bnms_pkg::IN_TDATA_W-1:0]  i_box_data,
    input  wire logic                             i_box_first,
    // configuration writes
    input  wire logic                             i_cfg_we,
    input  wire logic [bnms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bnms_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // control
    input  wire bnms_pkg::t_cmd                   i_cmd,
    output bnms_pkg::t_status                     o_status,
    // result
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic [bnms_pkg::OUT_TDATA_W-1:0]      o_out_data,
    output logic [bnms_pkg::OUT_TUSER_W-1:0]      o_out_user
);
    import bnms_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);
    localparam int PW = $clog2(MAX_PROPOSALS);
    localparam int EW = AREA_W + CLASS_W + 4 * COORD_W;
    localparam int UW = AREA_W + 1;
    localparam int MW = THR_W + UW;

    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_KEPT);
    localparam logic [PW-1:0] PROP_TOP = PW'(MAX_PROPOSALS - 1);

    // Length of [lo, hi) clamped at zero
    function automatic logic [COORD_W-1:0] span_len(
        input logic signed [COORD_W-1:0] lo,
        input logic signed [COORD_W-1:0] hi
    );
        logic signed [COORD_W:0] diff;
        diff = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
        return (hi > lo) ? diff[COORD_W-1:0] : '0;
    endfunction

    // Overlap of two intervals, clamped at zero
    function automatic logic [COORD_W-1:0] overlap(
        input logic signed [COORD_W-1:0] a0,
        input logic signed [COORD_W-1:0] a1,
        input logic signed [COORD_W-1:0] b0,
        input logic signed [COORD_W-1:0] b1
    );
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return span_len(lo, hi);
    endfunction

    // Configuration
    logic [THR_W-1:0] r_thr;
    logic             r_agnostic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= THR_RESET;
            r_agnostic <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IOU_THRESHOLD) begin
                r_thr <= i_cfg_data;
            end
            if (i_cfg_index == CFG_CLASS_AGNOSTIC) begin
                r_agnostic <= i_cfg_data[0];
            end
        end
    end

    // Current box
    logic signed [COORD_W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [CLASS_W-1:0]        r_cls;
    logic [COORD_W-1:0]        r_spx, r_spy;
    logic [AREA_W-1:0]         r_area;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x0  <= i_box_data[0*COORD_W +: COORD_W];
            r_y0  <= i_box_data[1*COORD_W +: COORD_W];
            r_x1  <= i_box_data[2*COORD_W +: COORD_W];
            r_y1  <= i_box_data[3*COORD_W +: COORD_W];
            r_cls <= i_box_data[4*COORD_W +: CLASS_W];
        end
        if (i_cmd.span) begin
            r_spx <= span_len(r_x0, r_x1);
            r_spy <= span_len(r_y0, r_y1);
        end
        if (i_cmd.area) begin
            r_area <= AREA_W'(r_spx) * AREA_W'(r_spy);
        end
    end

    // Counters: kept entries, box position in frame, scan position
    logic [CW-1:0] r_count;
    logic [PW-1:0] r_prop;
    logic [AW-1:0] r_scan;
    logic          r_suppress;
    logic          keep;
    logic          store;

    assign keep  = !r_suppress;
    assign store = keep && (r_count < CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prop  <= '0;
            r_scan  <= '0;
        end else begin
            if (i_cmd.load) begin
                r_scan <= '0;
                if (i_box_first) begin
                    r_count <= '0;
                    r_prop  <= '0;
                end
            end
            if (i_cmd.issue) begin
                r_scan <= r_scan + AW'(1);
            end
            if (i_cmd.commit) begin
                if (store) begin
                    r_count <= r_count + CW'(1);
                end
                r_prop <= (r_prop == PROP_TOP) ? '0 : r_prop + PW'(1);
            end
        end
    end

    // Kept-list memory: one write port, one registered read port
    logic [EW-1:0] mem [MAX_KEPT];
    logic [EW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && store) begin
            mem[r_count[AW-1:0]] <= {r_area, r_cls, r_y1, r_x1, r_y0, r_x0};
        end
        if (i_cmd.issue) begin
            r_rd <= mem[r_scan];
        end
    end

    // Unpack the read entry
    logic signed [COORD_W-1:0] k_x0, k_y0, k_x1, k_y1;
    logic [CLASS_W-1:0]        k_cls;
    logic [AREA_W-1:0]         k_area;

    assign k_x0   = r_rd[0*COORD_W +: COORD_W];
    assign k_y0   = r_rd[1*COORD_W +: COORD_W];
    assign k_x1   = r_rd[2*COORD_W +: COORD_W];
    assign k_y1   = r_rd[3*COORD_W +: COORD_W];
    assign k_cls  = r_rd[4*COORD_W +: CLASS_W];
    assign k_area = r_rd[4*COORD_W + CLASS_W +: AREA_W];

    // IoU pipeline: overlap, intersection, union, scaled union, compare
    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [COORD_W-1:0]   r_ovx, r_ovy;
    logic [AREA_W-1:0]    r_karea2, r_karea3;
    logic [AREA_W-1:0]    r_inter3, r_inter4, r_inter5;
    logic [UW-1:0]        r_union4;
    logic [MW-1:0]        r_scaled5;
    logic [UW-1:0]        union_sum;
    logic [MW-1:0]        inter_x256;

    assign union_sum  = {1'b0, r_area} + {1'b0, r_karea3} - {1'b0, r_inter3};
    assign inter_x256 = MW'({r_inter5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1 && (r_agnostic || (k_cls == r_cls));
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovx     <= overlap(r_x0, r_x1, k_x0, k_x1);
        r_ovy     <= overlap(r_y0, r_y1, k_y0, k_y1);
        r_karea2  <= k_area;
        r_inter3  <= AREA_W'(r_ovx) * AREA_W'(r_ovy);
        r_karea3  <= r_karea2;
        r_union4  <= union_sum;
        r_inter4  <= r_inter3;
        r_scaled5 <= MW'(r_thr) * MW'(r_union4);
        r_inter5  <= r_inter4;
    end

    // Sticky suppress flag, cleared per box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_suppress <= 1'b0;
        end else if (i_cmd.load) begin
            r_suppress <= 1'b0;
        end else if (r_v5 && (inter_x256 > r_scaled5)) begin
            r_suppress <= 1'b1;
        end
    end

    // Output register
    logic                r_out_valid;
    logic                r_out_keep;
    logic                r_out_ovf;
    logic [INDEX_W-1:0]  r_out_index;
    logic [TOTAL_W-1:0]  r_out_total;
    logic [CW-1:0]       count_after;

    assign count_after = store ? r_count + CW'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_keep  <= keep;
            r_out_ovf   <= keep && !store;
            r_out_index <= INDEX_W'(r_prop);
            r_out_total <= TOTAL_W'(count_after);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = OUT_TDATA_W'({r_out_total, r_out_index});
    assign o_out_user  = {r_out_ovf, r_out_keep};

    // Status to the controller
    assign o_status.count_zero = (r_count == '0);
    assign o_status.scan_last  = (CW'(r_scan) + CW'(1) == r_count);
    assign o_status.pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

endmodule : bnms_datapath
`default_nettype wire

// File: sim/box_non_max_suppression_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_non_max_suppression_top_test: self-checking bench for box suppression
// Streams boxes into the block, predicts each keep/suppress verdict in a
// scoreboard class that tracks its own kept list, and compares every result
// transfer field by field under random backpressure and threshold settings.
// ----------------------------------------------------------------------------
module box_non_max_suppression_top_test;
    import bnms_pkg::*;

    localparam int LIST_DEPTH  = DEF_MAX_KEPT;
    localparam int INDEX_SPAN  = DEF_MAX_PROPOSALS;
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic [CLASS_W-1:0]        cls;
        logic                      first;
    } t_box;

    typedef struct {
        logic               keep;
        logic [INDEX_W-1:0] index;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Verdict tracker: own kept list, own settings, queue of pending verdicts
    // ------------------------------------------------------------------------
    class keep_predictor;
        t_box              kept_box[LIST_DEPTH];
        longint unsigned   kept_area[LIST_DEPTH];
        int unsigned       kept_count;
        int unsigned       box_count;
        logic [THR_W-1:0]  threshold;
        logic              agnostic;
        t_verdict          expected_verdicts[$];
        int unsigned       failures;

        function new();
            kept_count = 0;
            box_count  = 0;
            threshold  = THR_RESET;
            agnostic   = 1'b0;
            failures   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IOU_THRESHOLD:  threshold = data;
                CFG_CLASS_AGNOSTIC: agnostic  = data[0];
                default: ;
            endcase
        endfunction

        function longint unsigned span(int lo, int hi);
            return (hi > lo) ? longint'(hi - lo) : 64'd0;
        endfunction

        function longint unsigned overlap(int a0, int a1, int b0, int b1);
            return span((a0 > b0) ? a0 : b0, (a1 < b1) ? a1 : b1);
        endfunction

        // Work out the verdict of one accepted box and update the kept list
        function void note_box(t_box b);
            t_verdict        v;
            longint unsigned area;
            longint unsigned inter;
            longint unsigned uni;
            logic            keep;
            if (b.first) begin
                kept_count = 0;
                box_count  = 0;
            end
            area = span(b.x0, b.x1) * span(b.y0, b.y1);
            keep = 1'b1;
            for (int j = 0; j < kept_count; j++) begin
                if (agnostic || kept_box[j].cls == b.cls) begin
                    inter = overlap(b.x0, b.x1, kept_box[j].x0, kept_box[j].x1)
                          * overlap(b.y0, b.y1, kept_box[j].y0, kept_box[j].y1);
                    uni = area + kept_area[j] - inter;
                    if (inter * 64'd256 > 64'(threshold) * uni)
                        keep = 1'b0;
                end
            end
            v.overflow = 1'b0;
            if (keep) begin
                if (kept_count < LIST_DEPTH) begin
                    kept_box[kept_count]  = b;
                    kept_area[kept_count] = area;
                    kept_count++;
                end else begin
                    v.overflow = 1'b1;
                end
            end
            v.keep  = keep;
            v.index = box_count[INDEX_W-1:0];
            v.total = kept_count[TOTAL_W-1:0];
            box_count = (box_count + 1) % INDEX_SPAN;
            expected_verdicts.insert(expected_verdicts.size(), v);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        // Match one result transfer against the oldest pending verdict
        function void check_verdict(logic [OUT_TDATA_W-1:0] tdata,
                                    logic [OUT_TUSER_W-1:0] tuser);
            t_verdict v;
            if (expected_verdicts.size() == 0) begin
                $error("result transfer with nothing pending: tdata %h tuser %h",
                       tdata, tuser);
                failures++;
                return;
            end
            v = expected_verdicts.pop_front();
            compare_field("keep", 32'(v.keep), 32'(tuser[0]));
            compare_field("list_overflow", 32'(v.overflow), 32'(tuser[1]));
            compare_field("proposal_index", 32'(v.index), 32'(tdata[INDEX_W-1:0]));
            compare_field("kept_total", 32'(v.total), 32'(tdata[INDEX_W +: TOTAL_W]));
        endfunction

        function void check_drained();
            if (expected_verdicts.size() != 0) begin
                $error("%0d pending verdicts never arrived", expected_verdicts.size());
                failures++;
            end
        endfunction

        function bit busy();
            return expected_verdicts.size() != 0;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, stimulus signals and the block
    // ------------------------------------------------------------------------
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   i_s_axis_tuser  = 1'b0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [OUT_TUSER_W-1:0] o_m_axis_tuser;
    logic                   o_cfg_ready;

    keep_predictor tracker;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            cycle_count;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    box_non_max_suppression_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Check each result transfer, then pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_verdict(o_m_axis_tdata, o_m_axis_tuser);
        i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Stop a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one box, hold it until the transfer, then record it
    task automatic send_box(input t_box b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            if (i_s_axis_tvalid)
                i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {b.cls, b.y1, b.x1, b.y0, b.x0};
        i_s_axis_tuser  <= b.first;
        do @(posedge i_clk); while (!o_s_axis_tready);
        tracker.note_box(b);
    endtask

    task automatic send_coords(input int x0, input int y0, input int x1, input int y1,
                               input int cls, input bit first);
        t_box b;
        b.x0    = 16'(x0);
        b.y0    = 16'(y0);
        b.x1    = 16'(x1);
        b.y1    = 16'(y1);
        b.cls   = 8'(cls);
        b.first = first;
        send_box(b);
    endtask

    // Drop valid and wait until every pending verdict has come back
    task automatic settle();
        if (i_s_axis_tvalid)
            i_s_axis_tvalid <= 1'b0;
        while (tracker.busy())
            @(posedge i_clk);
    endtask

    // Write one register on an idle block; hold valid when more writes follow
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input bit more);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, data);
        if (!more)
            i_cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure();
        logic [THR_W-1:0] thr;
        case ($urandom_range(0, 6))
            0:       thr = 9'd0;
            1:       thr = 9'd1;
            2:       thr = 9'd128;
            3:       thr = 9'd255;
            4:       thr = 9'd256;
            5:       thr = 9'd511;
            default: thr = 9'($urandom_range(0, 511));
        endcase
        write_reg(CFG_IOU_THRESHOLD, thr, 1'b1);
        if ($urandom_range(0, 3) == 0)
            write_reg(8'($urandom_range(2, 255)), 9'($urandom), 1'b1);
        write_reg(CFG_CLASS_AGNOSTIC, 9'($urandom), 1'b0);
    endtask

    // One frame of well-formed boxes in a random window, with some noise boxes
    task automatic send_frame(input int len, input int spread, input int size_max,
                              input int ncls);
        int   org_x;
        int   org_y;
        t_box b;
        org_x = -32768 + int'($urandom_range(0, 65535 - spread - size_max));
        org_y = -32768 + int'($urandom_range(0, 65535 - spread - size_max));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                b.x0    = 16'($urandom);
                b.y0    = 16'($urandom);
                b.x1    = 16'($urandom);
                b.y1    = 16'($urandom);
                b.cls   = 8'($urandom);
                b.first = 1'($urandom);
            end else begin
                b.x0    = 16'(org_x + $urandom_range(0, spread));
                b.y0    = 16'(org_y + $urandom_range(0, spread));
                b.x1    = 16'(b.x0 + $urandom_range(1, size_max));
                b.y1    = 16'(b.y0 + $urandom_range(1, size_max));
                b.cls   = 8'($urandom_range(0, ncls - 1));
                b.first = (i == 0);
            end
            send_box(b);
        end
    endtask

    task automatic run_random_phase(input int n_items);
        int sent;
        int len;
        int spread;
        int size_max;
        int ncls;
        // sparse frame that runs the kept list past its capacity
        send_frame(LIST_DEPTH + 20, 60000, 64, 256);
        sent = LIST_DEPTH + 20;
        while (sent < n_items) begin
            if ($urandom_range(0, 2) == 0)
                reconfigure();
            case ($urandom_range(0, 3))
                0:       spread = 32;
                1:       spread = 512;
                2:       spread = 4096;
                default: spread = 30000;
            endcase
            case ($urandom_range(0, 2))
                0:       size_max = 16;
                1:       size_max = 256;
                default: size_max = 4096;
            endcase
            case ($urandom_range(0, 3))
                0:       ncls = 1;
                1:       ncls = 2;
                2:       ncls = 4;
                default: ncls = 256;
            endcase
            len = $urandom_range(1, 40);
            send_frame(len, spread, size_max, ncls);
            sent += len;
        end
    endtask

    // Corner boxes, reset settings first, then threshold and class mode edges
    task automatic run_directed();
        send_coords(0, 0, 160, 160, 3, 1'b1);
        send_coords(0, 0, 160, 160, 3, 1'b0);             // identical, suppressed
        send_coords(0, 0, 160, 160, 4, 1'b0);             // other class survives
        send_coords(80, 0, 240, 160, 3, 1'b0);            // IoU one third
        send_coords(16, 16, 160, 160, 3, 1'b0);           // mostly inside
        send_coords(300, 300, 300, 400, 7, 1'b0);         // zero width
        send_coords(300, 300, 300, 400, 7, 1'b0);         // zero union
        send_coords(500, 500, 400, 400, 7, 1'b0);         // inverted corners
        send_coords(-32768, -32768, 32767, 32767, 255, 1'b0);
        send_coords(-32768, -32768, 32767, 32767, 255, 1'b0);
        send_coords(-32768, -32768, -32767, -32767, 0, 1'b0);
        send_coords(-1, -1, -1, -1, 255, 1'b0);
        send_coords(32766, 32766, 32767, 32767, 255, 1'b0);
        // any overlap suppresses, classes ignored
        write_reg(CFG_IOU_THRESHOLD, 9'd0, 1'b1);
        write_reg(CFG_CLASS_AGNOSTIC, 9'h1FF, 1'b0);
        send_coords(1, 1, 2, 2, 9, 1'b0);
        // full overlap exactly at the limit is not above it
        write_reg(CFG_IOU_THRESHOLD, 9'd256, 1'b0);
        send_coords(0, 0, 160, 160, 3, 1'b0);
        write_reg(CFG_IOU_THRESHOLD, 9'd511, 1'b0);
        send_coords(0, 0, 160, 160, 3, 1'b0);
        write_reg(CFG_IOU_THRESHOLD, 9'd255, 1'b0);
        send_coords(0, 0, 160, 160, 3, 1'b0);
        // unknown register indexes leave settings alone
        write_reg(8'd2, 9'd0, 1'b1);
        write_reg(8'd255, 9'h1FF, 1'b0);
        send_coords(0, 0, 160, 160, 3, 1'b0);
        write_reg(CFG_CLASS_AGNOSTIC, 9'h1FE, 1'b0);
        send_coords(0, 0, 160, 160, 200, 1'b0);
        send_coords(0, 0, 160, 160, 200, 1'b1);           // new frame clears list
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 26;
        recv_idle_pct = 87;
        run_directed();
        run_random_phase(235);

        send_idle_pct = 87;
        recv_idle_pct = 26;
        reconfigure();
        run_random_phase(235);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        reconfigure();
        run_random_phase(235);

        settle();
        repeat (LIST_DEPTH + 32) @(posedge i_clk);
        tracker.check_drained();
        if (tracker.failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
